/* hdl/pfr_pkg.sv */
// Package for the packet frame receiver: event codes, classified-operation codes,
// register indexes and the structs passed between the front, queue and back.
// No dependencies.
package pfr_pkg;

	// Frame layout
	localparam int unsigned HEADER_BYTES = 5;
	localparam int unsigned FLAG_BYTES   = 4;
	localparam int unsigned FOOTER_BYTES = 7;

	// Result event codes
	localparam logic [2:0] EV_DISCARD  = 3'd0;
	localparam logic [2:0] EV_FRAMING  = 3'd1;
	localparam logic [2:0] EV_PAYLOAD  = 3'd2;
	localparam logic [2:0] EV_DONE     = 3'd3;
	localparam logic [2:0] EV_OVERFLOW = 3'd4;

	// Operation kinds produced by the front
	localparam logic [2:0] OP_DISCARD  = 3'd0;
	localparam logic [2:0] OP_START    = 3'd1;
	localparam logic [2:0] OP_HEADER   = 3'd2;
	localparam logic [2:0] OP_PAYLOAD  = 3'd3;
	localparam logic [2:0] OP_FLAG     = 3'd4;
	localparam logic [2:0] OP_CKSUM    = 3'd5;
	localparam logic [2:0] OP_DONE     = 3'd6;
	localparam logic [2:0] OP_OVERFLOW = 3'd7;

	// Header field select, taken from the low bits of the byte position
	localparam logic [1:0] HDR_LEN_LO  = 2'd0;
	localparam logic [1:0] HDR_MODULE  = 2'd1;
	localparam logic [1:0] HDR_COMMAND = 2'd2;
	localparam logic [1:0] HDR_LEN_HI  = 2'd3;

	// Configuration register indexes
	localparam logic [2:0] REG_START_SYMBOL   = 3'd0;
	localparam logic [2:0] REG_END_SYMBOL     = 3'd1;
	localparam logic [2:0] REG_MODULE_LIMIT   = 3'd2;
	localparam logic [2:0] REG_LENGTH_LIMIT   = 3'd3;
	localparam logic [2:0] REG_FRAME_CAPACITY = 3'd4;

	typedef struct packed {
		logic [7:0]  start_symbol;
		logic [7:0]  end_symbol;
		logic [7:0]  module_id_limit;
		logic [15:0] payload_length_limit;
		logic [15:0] frame_capacity;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  data;
		logic [15:0] pos;
		logic [1:0]  sel;
	} op_t;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [7:0]  data_byte;
		logic [15:0] byte_position;
		logic [7:0]  module_id;
		logic [7:0]  command;
		logic [15:0] payload_length;
		logic [31:0] frame_flags;
		logic [3:0]  error_flags;
		logic        frame_last;
	} res_t;

endpackage

/* hdl/pfr_front.sv */
// Front of the packet frame receiver: accepts bytes, tracks frame phase and position,
// and classifies each byte into an operation for the back. Depends on pfr_pkg.
module pfr_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rx_valid,
	output logic          rx_ready,
	input  logic [7:0]    rx_byte,
	input  pfr_pkg::cfg_t cfg,
	output logic          op_valid,
	input  logic          op_ready,
	output pfr_pkg::op_t  op
);
	import pfr_pkg::*;

	localparam logic [1:0] PH_WAIT    = 2'd0;
	localparam logic [1:0] PH_HEADER  = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;
	localparam logic [1:0] PH_FOOTER  = 2'd3;

	logic [1:0]  phase_q, phase_d;
	logic [15:0] count_q, count_d;
	logic [15:0] len_q, len_d;
	logic        in_frame;
	logic [15:0] pos;
	logic [15:0] pos_inc;
	logic [15:0] new_len;
	logic        pay_end;
	logic [16:0] foot_idx;
	logic        take;

	// Transfer happens whenever a byte is valid and the queue has room
	assign rx_ready = op_ready;
	assign op_valid = rx_valid;
	assign take     = rx_valid && op_ready;

	// Classify the incoming byte and compute the next phase
	always_comb begin
		in_frame = (phase_q != PH_WAIT);
		pos      = in_frame ? count_q : 16'd0;
		pos_inc  = pos + 16'd1;
		new_len  = {len_q[15:8], rx_byte};
		pay_end  = ({1'b0, pos} + 17'd1) == (17'(HEADER_BYTES) + {1'b0, len_q});
		foot_idx = {1'b0, pos} - 17'(HEADER_BYTES) - {1'b0, len_q};
		phase_d  = phase_q;
		count_d  = count_q;
		len_d    = len_q;
		op.kind  = OP_DISCARD;
		op.data  = rx_byte;
		op.pos   = pos;
		op.sel   = pos[1:0];
		if (!in_frame && (rx_byte != cfg.start_symbol)) begin
			op.kind = OP_DISCARD;
			phase_d = PH_WAIT;
		end else if (pos >= cfg.frame_capacity) begin
			op.kind = OP_OVERFLOW;
			phase_d = PH_WAIT;
			count_d = 16'd0;
		end else if (!in_frame) begin
			op.kind = OP_START;
			phase_d = PH_HEADER;
			count_d = 16'd1;
		end else begin
			count_d = pos_inc;
			unique case (phase_q)
				PH_HEADER: begin
					op.kind = OP_HEADER;
					if (pos == 16'd3) begin
						len_d = {rx_byte, len_q[7:0]};
					end else if (pos == 16'd4) begin
						len_d   = new_len;
						phase_d = (new_len == 16'd0) ? PH_FOOTER : PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					op.kind = OP_PAYLOAD;
					if (pay_end) begin
						phase_d = PH_FOOTER;
					end
				end
				default: begin
					if (foot_idx < 17'(FLAG_BYTES)) begin
						op.kind = OP_FLAG;
					end else if (foot_idx < 17'(FOOTER_BYTES - 1)) begin
						op.kind = OP_CKSUM;
					end else begin
						op.kind = OP_DONE;
						phase_d = PH_WAIT;
						count_d = 16'd0;
					end
				end
			endcase
		end
	end

	// Advance phase, position and length on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			count_q <= 16'd0;
			len_q   <= 16'd0;
		end else if (take) begin
			phase_q <= phase_d;
			count_q <= count_d;
			len_q   <= len_d;
		end
	end

endmodule

/* hdl/pfr_queue.sv */
// Short operation queue between front and back of the packet frame receiver.
// Depends on pfr_pkg.
module pfr_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  pfr_pkg::op_t push_op,
	output logic         pop_valid,
	input  logic         pop_ready,
	output pfr_pkg::op_t pop_op
);
	import pfr_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	op_t              entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_op     = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Store the pushed entry
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/pfr_back.sv */
// Back of the packet frame receiver: runs the checksum, holds header and footer fields,
// checks the frame at its end and drives the result register. Depends on pfr_pkg.
module pfr_back (
	input  logic          clk,
	input  logic          arst_n,
	input  pfr_pkg::cfg_t cfg,
	input  logic          op_valid,
	output logic          op_ready,
	input  pfr_pkg::op_t  op,
	output logic          res_valid,
	input  logic          res_ready,
	output pfr_pkg::res_t res
);
	import pfr_pkg::*;

	logic [15:0] sum_q, sum_d;
	logic [7:0]  mod_q, mod_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [15:0] len_q, len_d;
	logic [31:0] flags_q, flags_d;
	logic [15:0] cksum_q, cksum_d;
	logic [15:0] sum_add;
	logic [15:0] sum_neg;
	logic        mod_over;
	logic        len_over;
	logic        res_valid_q;
	res_t        res_q, res_d;
	logic        take;

	assign take      = op_valid && (!res_valid_q || res_ready);
	assign op_ready  = !res_valid_q || res_ready;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Carry out one operation and build its result
	always_comb begin
		sum_add  = sum_q + {8'd0, op.data};
		sum_neg  = 16'd0 - sum_q;
		mod_over = (mod_q > cfg.module_id_limit);
		len_over = (len_q > cfg.payload_length_limit);
		sum_d    = sum_q;
		mod_d    = mod_q;
		cmd_d    = cmd_q;
		len_d    = len_q;
		flags_d  = flags_q;
		cksum_d  = cksum_q;
		res_d               = '0;
		res_d.byte_position = op.pos;
		res_d.event_res     = EV_FRAMING;
		unique case (op.kind)
			OP_DISCARD: begin
				res_d.event_res = EV_DISCARD;
			end
			OP_OVERFLOW: begin
				res_d.event_res  = EV_OVERFLOW;
				res_d.frame_last = 1'b1;
			end
			OP_START: begin
				sum_d = {8'd0, op.data};
			end
			OP_HEADER: begin
				sum_d = sum_add;
				case (op.sel)
					HDR_MODULE:  mod_d = op.data;
					HDR_COMMAND: cmd_d = op.data;
					HDR_LEN_HI:  len_d = {op.data, len_q[7:0]};
					default:     len_d = {len_q[15:8], op.data};
				endcase
			end
			OP_PAYLOAD: begin
				sum_d           = sum_add;
				res_d.event_res = EV_PAYLOAD;
				res_d.data_byte = op.data;
			end
			OP_FLAG: begin
				sum_d   = sum_add;
				flags_d = {flags_q[23:0], op.data};
			end
			OP_CKSUM: begin
				cksum_d = {cksum_q[7:0], op.data};
			end
			default: begin
				res_d.event_res      = EV_DONE;
				res_d.frame_last     = 1'b1;
				res_d.module_id      = mod_q;
				res_d.command        = cmd_q;
				res_d.payload_length = len_q;
				res_d.frame_flags    = flags_q;
				res_d.error_flags[0] = mod_over;
				res_d.error_flags[1] = len_over;
				if (!mod_over && !len_over) begin
					res_d.error_flags[2] = (sum_neg != cksum_q);
					res_d.error_flags[3] = (op.data != cfg.end_symbol);
				end
			end
		endcase
	end

	// Hold frame state, update on each transfer from the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= 16'd0;
			mod_q   <= 8'd0;
			cmd_q   <= 8'd0;
			len_q   <= 16'd0;
			flags_q <= 32'd0;
			cksum_q <= 16'd0;
		end else if (take) begin
			sum_q   <= sum_d;
			mod_q   <= mod_d;
			cmd_q   <= cmd_d;
			len_q   <= len_d;
			flags_q <= flags_d;
			cksum_q <= cksum_d;
		end
	end

	// Result register: load on transfer in, drop on transfer out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_d;
		end
	end

`ifndef ASSERT_OFF
	a_last_matches_event: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.frame_last ==
			((res_q.event_res == EV_DONE) || (res_q.event_res == EV_OVERFLOW))))
		else $error("frame_last disagrees with event");
	a_errors_only_at_done: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && (res_q.event_res != EV_DONE)) |-> (res_q.error_flags == 4'd0))
		else $error("error flags outside frame done");
	a_data_only_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && (res_q.event_res != EV_PAYLOAD)) |-> (res_q.data_byte == 8'd0))
		else $error("data byte outside payload");
	a_discard_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && (res_q.event_res == EV_DISCARD)) |-> (res_q.byte_position == 16'd0))
		else $error("discarded byte with nonzero position");
`endif

endmodule

/* hdl/packet_frame_receiver_core.sv */
// Packet frame receiver: one byte per cycle sustained while results are taken,
// limited by the front's phase and position register loop. A byte is written into
// the queue when it transfers in, and its result is then loaded into the result register.
// Reset: configuration returns to its defaults, the queue and result register
// empty, and the receiver waits for a start symbol. Depends on pfr_pkg.
module packet_frame_receiver_core #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_ready,
	input  logic [7:0]  rx_byte,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [2:0]  event_res,
	output logic [7:0]  data_byte,
	output logic [15:0] byte_position,
	output logic [7:0]  module_id,
	output logic [7:0]  command,
	output logic [15:0] payload_length,
	output logic [31:0] frame_flags,
	output logic [3:0]  error_flags,
	output logic        frame_last,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import pfr_pkg::*;

	cfg_t cfg_q;
	logic f_valid, f_ready;
	op_t  f_op;
	logic b_valid, b_ready;
	op_t  b_op;
	res_t res;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_symbol         <= 8'd1;
			cfg_q.end_symbol           <= 8'd4;
			cfg_q.module_id_limit      <= 8'd255;
			cfg_q.payload_length_limit <= 16'd1024;
			cfg_q.frame_capacity       <= 16'd2048;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_SYMBOL:   cfg_q.start_symbol         <= cfg_data[7:0];
				REG_END_SYMBOL:     cfg_q.end_symbol           <= cfg_data[7:0];
				REG_MODULE_LIMIT:   cfg_q.module_id_limit      <= cfg_data[7:0];
				REG_LENGTH_LIMIT:   cfg_q.payload_length_limit <= cfg_data;
				REG_FRAME_CAPACITY: cfg_q.frame_capacity       <= cfg_data;
				default: ;
			endcase
		end
	end

	pfr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_ready (rx_ready),
		.rx_byte  (rx_byte),
		.cfg      (cfg_q),
		.op_valid (f_valid),
		.op_ready (f_ready),
		.op       (f_op)
	);

	pfr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_op    (f_op),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_op     (b_op)
	);

	pfr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.op_valid  (b_valid),
		.op_ready  (b_ready),
		.op        (b_op),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Unpack the result onto its ports
	assign event_res      = res.event_res;
	assign data_byte      = res.data_byte;
	assign byte_position  = res.byte_position;
	assign module_id      = res.module_id;
	assign command        = res.command;
	assign payload_length = res.payload_length;
	assign frame_flags    = res.frame_flags;
	assign error_flags    = res.error_flags;
	assign frame_last     = res.frame_last;

endmodule
